// File: design/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and character constants of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int KIND_W   = 3;
    localparam int OFFSET_W = 32;
    localparam int LENGTH_W = 16;
    localparam int LINE_W   = 24;
    localparam int COLUMN_W = 16;
    localparam int SYMBOL_W = 8;
    localparam int SLOTS    = 3;

    localparam logic [7:0] C_NUL      = 8'h00;
    localparam logic [7:0] C_TAB      = 8'h09;
    localparam logic [7:0] C_NL       = 8'h0A;
    localparam logic [7:0] C_CR       = 8'h0D;
    localparam logic [7:0] C_SPACE    = 8'h20;
    localparam logic [7:0] C_PRINT_LO = 8'h21;
    localparam logic [7:0] C_PRINT_HI = 8'h7E;
    localparam logic [7:0] C_DOT      = 8'h2E;
    localparam logic [7:0] C_USCORE   = 8'h5F;
    localparam logic [7:0] C_ZERO     = 8'h30;
    localparam logic [7:0] C_NINE     = 8'h39;
    localparam logic [7:0] C_LOW_A    = 8'h61;
    localparam logic [7:0] C_LOW_Z    = 8'h7A;
    localparam logic [7:0] C_UP_A     = 8'h41;
    localparam logic [7:0] C_UP_Z     = 8'h5A;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_INT_DOT = 3'd3,
        MODE_FLOAT   = 3'd4
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENT   = 3'd0,
        KIND_INT     = 3'd1,
        KIND_FLOAT   = 3'd2,
        KIND_SYMBOL  = 3'd3,
        KIND_INVALID = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [OFFSET_W-1:0]  offset;
        logic [LENGTH_W-1:0]  length;
        logic [LINE_W-1:0]    line;
        logic [COLUMN_W-1:0]  column;
        logic [SYMBOL_W-1:0]  symbol;
    } t_token;

    // Slot 0 is the pending token, slot 1 a held-back dot, slot 2 the byte itself.
    typedef struct packed {
        logic [SLOTS-1:0]     valid;
        t_token [SLOTS-1:0]   tok;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: design/stok_front.sv
// ----------------------------------------------------------------------------
// stok_front
// Scanner: tracks position and token state and pushes each byte's tokens.
// ----------------------------------------------------------------------------
module stok_front #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_source_byte,
    input  stok_pkg::t_queue_status i_status,
    output logic                   o_push,
    output stok_pkg::t_bundle      o_bundle
);
    import stok_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_ts_off, n_ts_off;
    logic [LINE_BITS-1:0]   r_line, n_line, r_ts_line, n_ts_line;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_ts_col, n_ts_col;
    logic [LENGTH_BITS-1:0] r_len, n_len;

    logic accept;

    function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction
    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
    endfunction
    function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
        return (v == COL_MAX) ? v : v + COLUMN_BITS'(1);
    endfunction
    function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LENGTH_BITS'(1);
    endfunction

    // Counters are masked or zero-extended to the fixed field widths.
    function automatic logic [OFFSET_W-1:0] off_out(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OFFSET_W-1:0];
    endfunction
    function automatic logic [LINE_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[LINE_W-1:0];
    endfunction
    function automatic logic [COLUMN_W-1:0] col_out(input logic [COLUMN_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[COLUMN_W-1:0];
    endfunction
    function automatic logic [LENGTH_W-1:0] len_out(input logic [LENGTH_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[LENGTH_W-1:0];
    endfunction

    assign o_ready = !i_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        logic [7:0]             b;
        logic                   is_digit, is_alpha, fall;
        logic [OFFSET_BITS-1:0] off1;
        logic [COLUMN_BITS-1:0] col1;
        b        = i_source_byte;
        is_digit = b inside {[C_ZERO:C_NINE]};
        is_alpha = b inside {[C_LOW_A:C_LOW_Z], [C_UP_A:C_UP_Z], C_USCORE};
        fall     = 1'b1;
        off1     = r_off;
        col1     = r_col;

        n_mode    = r_mode;
        n_off     = r_off;
        n_line    = r_line;
        n_col     = r_col;
        n_ts_off  = r_ts_off;
        n_ts_line = r_ts_line;
        n_ts_col  = r_ts_col;
        n_len     = r_len;

        o_bundle.valid         = '0;
        o_bundle.tok[0].kind   = KIND_IDENT;
        o_bundle.tok[0].offset = off_out(r_ts_off);
        o_bundle.tok[0].length = len_out(r_len);
        o_bundle.tok[0].line   = line_out(r_ts_line);
        o_bundle.tok[0].column = col_out(r_ts_col);
        o_bundle.tok[0].symbol = '0;
        o_bundle.tok[1].kind   = KIND_SYMBOL;
        o_bundle.tok[1].offset = off_out(r_off);
        o_bundle.tok[1].length = LENGTH_W'(1);
        o_bundle.tok[1].line   = line_out(r_line);
        o_bundle.tok[1].column = col_out(r_col);
        o_bundle.tok[1].symbol = C_DOT;
        o_bundle.tok[2].kind   = KIND_SYMBOL;
        o_bundle.tok[2].length = LENGTH_W'(1);
        o_bundle.tok[2].line   = line_out(r_line);
        o_bundle.tok[2].symbol = '0;

        if (b == C_NUL) begin
            fall = 1'b0;
            case (r_mode)
                MODE_IDENT: begin
                    o_bundle.valid[0] = 1'b1;
                end
                MODE_INT: begin
                    o_bundle.valid[0]    = 1'b1;
                    o_bundle.tok[0].kind = KIND_INT;
                end
                MODE_FLOAT: begin
                    o_bundle.valid[0]    = 1'b1;
                    o_bundle.tok[0].kind = KIND_FLOAT;
                end
                MODE_INT_DOT: begin
                    o_bundle.valid[1:0]  = 2'b11;
                    o_bundle.tok[0].kind = KIND_INT;
                end
                default: begin
                end
            endcase
            n_mode = MODE_IDLE;
            n_off  = '0;
            n_line = LINE_BITS'(1);
            n_col  = COLUMN_BITS'(1);
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (is_alpha || is_digit) begin
                        fall  = 1'b0;
                        n_len = inc_len(r_len);
                        n_off = inc_off(r_off);
                        n_col = inc_col(r_col);
                    end else begin
                        o_bundle.valid[0] = 1'b1;
                    end
                end
                MODE_INT: begin
                    o_bundle.tok[0].kind = KIND_INT;
                    if (is_digit) begin
                        fall  = 1'b0;
                        n_len = inc_len(r_len);
                        n_off = inc_off(r_off);
                        n_col = inc_col(r_col);
                    end else if (b == C_DOT) begin
                        // The dot is held uncounted until the next byte decides.
                        fall   = 1'b0;
                        n_mode = MODE_INT_DOT;
                    end else begin
                        o_bundle.valid[0] = 1'b1;
                    end
                end
                MODE_INT_DOT: begin
                    o_bundle.tok[0].kind = KIND_INT;
                    if (is_digit) begin
                        fall   = 1'b0;
                        n_len  = inc_len(inc_len(r_len));
                        n_off  = inc_off(inc_off(r_off));
                        n_col  = inc_col(inc_col(r_col));
                        n_mode = MODE_FLOAT;
                    end else begin
                        o_bundle.valid[1:0] = 2'b11;
                        off1 = inc_off(r_off);
                        col1 = inc_col(r_col);
                    end
                end
                MODE_FLOAT: begin
                    o_bundle.tok[0].kind = KIND_FLOAT;
                    if (is_digit) begin
                        fall  = 1'b0;
                        n_len = inc_len(r_len);
                        n_off = inc_off(r_off);
                        n_col = inc_col(r_col);
                    end else begin
                        o_bundle.valid[0] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        o_bundle.tok[2].offset = off_out(off1);
        o_bundle.tok[2].column = col_out(col1);

        if (fall) begin
            n_mode = MODE_IDLE;
            n_off  = inc_off(off1);
            n_col  = inc_col(col1);
            if (b == C_NL) begin
                n_line = inc_line(r_line);
                n_col  = COLUMN_BITS'(1);
            end else if (b == C_SPACE || b == C_TAB || b == C_CR) begin
            end else if (is_alpha || is_digit) begin
                n_mode    = is_alpha ? MODE_IDENT : MODE_INT;
                n_ts_off  = off1;
                n_ts_line = r_line;
                n_ts_col  = col1;
                n_len     = LENGTH_BITS'(1);
            end else if (b inside {[C_PRINT_LO:C_PRINT_HI]}) begin
                o_bundle.valid[2]      = 1'b1;
                o_bundle.tok[2].symbol = b;
            end else begin
                o_bundle.valid[2]    = 1'b1;
                o_bundle.tok[2].kind = KIND_INVALID;
            end
        end
    end

    assign o_push = accept && (o_bundle.valid != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_off     <= '0;
            r_line    <= LINE_BITS'(1);
            r_col     <= COLUMN_BITS'(1);
            r_ts_off  <= '0;
            r_ts_line <= LINE_BITS'(1);
            r_ts_col  <= COLUMN_BITS'(1);
            r_len     <= '0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_off     <= n_off;
            r_line    <= n_line;
            r_col     <= n_col;
            r_ts_off  <= n_ts_off;
            r_ts_line <= n_ts_line;
            r_ts_col  <= n_ts_col;
            r_len     <= n_len;
        end
    end

    a_nul_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_source_byte == C_NUL |=> r_off == '0 && r_mode == MODE_IDLE
            && r_line == LINE_BITS'(1) && r_col == COLUMN_BITS'(1))
        else $error("end of source did not restart the position");

    a_dot_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_INT_DOT |-> r_len != '0)
        else $error("pending dot without integer digits");

endmodule

// File: design/stok_queue.sv
// ----------------------------------------------------------------------------
// stok_queue
// Small FIFO of per-byte token bundles between scanner and output stage.
// ----------------------------------------------------------------------------
module stok_queue #(
    parameter int DEPTH = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  stok_pkg::t_bundle       i_data,
    input  logic                    i_pop,
    output stok_pkg::t_bundle       o_head,
    output stok_pkg::t_queue_status o_status
);
    import stok_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_status.full  = (r_cnt == FULL_CNT);
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rd];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from an empty queue");

endmodule

// File: design/stok_back.sv
// ----------------------------------------------------------------------------
// stok_back
// Output stage: serializes the tokens of each bundle into the output register.
// ----------------------------------------------------------------------------
module stok_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  stok_pkg::t_bundle       i_head,
    input  stok_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output stok_pkg::t_token        o_token,
    output logic                    o_last
);
    import stok_pkg::*;

    logic [SLOTS-1:0] r_done, n_done;
    logic             r_valid, n_valid;
    t_token           r_tok, n_tok;
    logic             r_last, n_last;

    logic [SLOTS-1:0] rem, sel;
    logic [1:0]       pick;
    logic             free, load, fin;

    always_comb begin
        rem  = i_status.empty ? '0 : (i_head.valid & ~r_done);
        free = !r_valid || i_ready;
        load = free && (rem != '0);
        if (rem[0]) begin
            pick = 2'd0;
        end else if (rem[1]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
        sel = SLOTS'(1) << pick;
        // The token is the last of its byte when nothing else remains in the bundle.
        fin = ((rem & ~sel) == '0);

        n_valid = free ? (rem != '0) : r_valid;
        n_tok   = r_tok;
        n_last  = r_last;
        n_done  = r_done;
        o_pop   = 1'b0;
        if (load) begin
            n_tok  = i_head.tok[pick];
            n_last = fin;
            if (fin) begin
                n_done = '0;
                o_pop  = 1'b1;
            end else begin
                n_done = r_done | sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok  <= n_tok;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            r_valid <= n_valid;
            r_done  <= n_done;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_tok;
    assign o_last  = r_last;

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_done == '0)
        else $error("slot marks survived a pop");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_status.empty |-> (r_done & ~i_head.valid) == '0)
        else $error("slot mark on an empty slot");

endmodule

// File: design/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming tokenizer: source bytes in, one token word per output handshake.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready with i_source_byte, one byte per word.
// A zero byte ends the source, flushes any pending token and restarts the
// offset, line and column for the next source.
// Output channel: o_valid / i_ready; each word is one token with its kind,
// start offset, length, line, column, symbol byte and o_last_of_run, which
// marks the final token caused by one input byte.
// The scanner takes one byte per cycle while the queue is not full and
// writes the tokens that byte completes (up to three) as one entry of a
// QUEUE_DEPTH-entry queue. The output register drains one token per cycle
// while the receiver is ready, so throughput is one byte per cycle while
// each byte yields at most one token; a byte with more tokens keeps its entry
// until all are loaded. A token passes the queue entry and then the output
// register. When the receiver stalls, the output holds, the queue fills,
// and o_ready drops only once the queue is full.
// Reset clears the scanner state, the queue and the output valid flag at once.
// ----------------------------------------------------------------------------
module source_tokenizer #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16,
    parameter int LENGTH_BITS = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_kind,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [23:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_symbol_byte,
    output logic        o_last_of_run
);
    import stok_pkg::*;

    t_queue_status w_status;
    t_bundle       w_push_data, w_head;
    logic          w_push, w_pop;
    t_token        w_tok;

    stok_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_source_byte (i_source_byte),
        .i_status      (w_status),
        .o_push        (w_push),
        .o_bundle      (w_push_data)
    );

    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    stok_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_token  (w_tok),
        .o_last   (o_last_of_run)
    );

    assign o_token_kind   = w_tok.kind;
    assign o_start_offset = w_tok.offset;
    assign o_token_length = w_tok.length;
    assign o_start_line   = w_tok.line;
    assign o_start_column = w_tok.column;
    assign o_symbol_byte  = w_tok.symbol;

endmodule
